FILE: hw/rtl/dqjs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqjs_pkg
// shared types, constants and the quadrature transition decoder
// ----------------------------------------------------------------------------
package dqjs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int STEP_WIDTH  = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_STEPS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_LEFT     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_RIGHT    = 8'd3;

    localparam logic [TICK_WIDTH-1:0] READ_INTERVAL_RST = 16'd1000;
    localparam logic [STEP_WIDTH-1:0] CLICK_STEPS_RST   = 8'd16;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX          = '1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        MOVE_HOLD = 2'd0,
        MOVE_UP   = 2'd1,
        MOVE_DOWN = 2'd2
    } t_move;

    typedef struct packed {
        logic                  flip;
        logic [STEP_WIDTH-1:0] click_steps;
    } t_lane_cfg;

    typedef struct packed {
        logic step;
        logic dir;
    } t_lane_out;

    typedef struct packed {
        logic step_left;
        logic dir_left;
        logic step_right;
        logic dir_right;
        logic pen_event;
    } t_result;

    // previous/new phase pair to count movement
    function automatic t_move decode_move(input logic [1:0] last, input logic [1:0] phase);
        logic [3:0] code;
        t_move      mv;
        code = {last, phase};
        unique case (code) inside
            4'd1, 4'd7, 4'd8, 4'd14:  mv = MOVE_UP;
            4'd2, 4'd4, 4'd11, 4'd13: mv = MOVE_DOWN;
            default:                  mv = MOVE_HOLD;
        endcase
        return mv;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dqjs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqjs_lane
// one encoder axis: phase decode, position count and step burst generator
// ----------------------------------------------------------------------------
module dqjs_lane (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_sample,
    input  wire logic [1:0]          i_phase,
    input  wire dqjs_pkg::t_lane_cfg i_cfg,
    output dqjs_pkg::t_lane_out      o_res
);
    import dqjs_pkg::*;

    logic [1:0]             r_last_phase, n_last_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_snap, n_snap;
    logic [STEP_WIDTH-1:0]  r_steps, n_steps;
    t_dir                   r_dir, n_dir;
    logic [COUNT_WIDTH-1:0] diff;
    t_move                  mv;

    always_comb begin
        mv           = decode_move(r_last_phase, i_phase);
        n_last_phase = r_last_phase;
        n_count      = r_count;
        if (i_sample) begin
            n_last_phase = i_phase;
            case (mv)
                MOVE_UP:   n_count = r_count + 1'b1;
                MOVE_DOWN: n_count = r_count - 1'b1;
                default:   n_count = r_count;
            endcase
        end
    end

    // flip swaps the operands, so half range stays negative either way
    assign diff = i_cfg.flip ? (r_snap - n_count) : (n_count - r_snap);

    always_comb begin
        n_snap  = r_snap;
        n_steps = r_steps;
        n_dir   = r_dir;
        o_res   = '0;
        if (r_steps == '0) begin
            n_snap = n_count;
            if (diff == '0) begin
                n_dir = DIR_NONE;
            end else if (diff[COUNT_WIDTH-1]) begin
                n_dir = DIR_NEG;
            end else begin
                n_dir = DIR_POS;
            end
            if (n_dir != DIR_NONE) begin
                n_steps = i_cfg.click_steps;
            end
        end else begin
            case (r_dir)
                DIR_POS: o_res = '{step: 1'b1, dir: 1'b1};
                DIR_NEG: o_res = '{step: 1'b1, dir: 1'b0};
                default: o_res = '0;
            endcase
            n_steps = r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= '0;
            r_count      <= '0;
            r_snap       <= '0;
            r_steps      <= '0;
            r_dir        <= DIR_NONE;
        end else if (i_accept) begin
            r_last_phase <= n_last_phase;
            r_count      <= n_count;
            r_snap       <= n_snap;
            r_steps      <= n_steps;
            r_dir        <= n_dir;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dqjs_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqjs_merge
// merges both lane results and the pen pulse into a two-entry output buffer
// ----------------------------------------------------------------------------
module dqjs_merge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire dqjs_pkg::t_lane_out i_left,
    input  wire dqjs_pkg::t_lane_out i_right,
    input  wire logic                i_pen,
    input  wire logic                i_out_ready,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output dqjs_pkg::t_result        o_res
);
    import dqjs_pkg::*;

    t_result r_main, r_skid, merged;
    logic    r_main_valid, r_skid_valid;
    logic    drain;

    assign merged = '{step_left:  i_left.step,  dir_left:  i_left.dir,
                      step_right: i_right.step, dir_right: i_right.dir,
                      pen_event:  i_pen};

    assign drain       = !r_main_valid || i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_res       = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            r_main_valid <= r_skid_valid || i_accept;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_main <= r_skid_valid ? r_skid : merged;
        end else if (i_accept) begin
            r_skid <= merged;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dual_quadrature_jog_stepper_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_quadrature_jog_stepper_top
// two quadrature encoders driving two stepper axes in bursts, plus pen pulse
// ----------------------------------------------------------------------------
// Each accepted input item is one sampling tick carrying both encoder phase
// pairs and both button flags; it yields exactly one result item with the
// step/direction requests of both axes and the pen pulse. The result is
// registered into the output buffer at acceptance, and a new item can be
// taken every clock while the buffer has room; the two-entry buffer keeps
// input accepting for one item while a result waits, after which o_ready
// follows i_ready through a register. The rate is set by the per-axis lane
// update (decode, count, signed compare), which is combinational.
// Configuration writes (index 0 read_interval, 1 click_steps, 2 flip_left,
// 3 flip_right) take effect at the write edge; other indexes are ignored.
// ----------------------------------------------------------------------------
module dual_quadrature_jog_stepper_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [dqjs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dqjs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_left_phase,
    input  wire logic [1:0]                    i_right_phase,
    input  wire logic                          i_left_button,
    input  wire logic                          i_right_button,
    // result items
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_step_left,
    output logic                               o_dir_left,
    output logic                               o_step_right,
    output logic                               o_dir_right,
    output logic                               o_pen_event
);
    import dqjs_pkg::*;

    // configuration registers
    logic [TICK_WIDTH-1:0] r_read_interval;
    logic [STEP_WIDTH-1:0] r_click_steps;
    logic                  r_flip_left;
    logic                  r_flip_right;

    // shared tick timer and pen tracking
    logic [TICK_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [TICK_WIDTH-1:0] tick_inc;
    logic                  r_button_held, n_button_held;
    logic                  sample;
    logic                  pen;
    logic                  accept;

    t_lane_cfg cfg_left, cfg_right;
    t_lane_out res_left, res_right;
    t_result   res;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_interval <= READ_INTERVAL_RST;
            r_click_steps   <= CLICK_STEPS_RST;
            r_flip_left     <= 1'b0;
            r_flip_right    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_READ_INTERVAL: r_read_interval <= i_cfg_data;
                CFG_CLICK_STEPS:   r_click_steps   <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_FLIP_LEFT:     r_flip_left     <= i_cfg_data[0];
                CFG_FLIP_RIGHT:    r_flip_right    <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // saturating tick count, sample once the interval is exceeded
    always_comb begin
        tick_inc  = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
        sample    = tick_inc > r_read_interval;
        n_elapsed = sample ? '0 : tick_inc;
    end

    // pen pulse when both buttons go released after any press
    always_comb begin
        n_button_held = r_button_held;
        pen           = 1'b0;
        if (!r_button_held && (i_left_button || i_right_button)) begin
            n_button_held = 1'b1;
        end else if (r_button_held && !i_left_button && !i_right_button) begin
            n_button_held = 1'b0;
            pen           = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= '0;
            r_button_held <= 1'b0;
        end else if (accept) begin
            r_elapsed     <= n_elapsed;
            r_button_held <= n_button_held;
        end
    end

    assign cfg_left  = '{flip: r_flip_left,  click_steps: r_click_steps};
    assign cfg_right = '{flip: r_flip_right, click_steps: r_click_steps};

    // one lane per axis
    dqjs_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (sample),
        .i_phase  (i_left_phase),
        .i_cfg    (cfg_left),
        .o_res    (res_left)
    );

    dqjs_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (sample),
        .i_phase  (i_right_phase),
        .i_cfg    (cfg_right),
        .o_res    (res_right)
    );

    // merge lane results into the output buffer
    dqjs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_left      (res_left),
        .i_right     (res_right),
        .i_pen       (pen),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_res       (res)
    );

    assign o_step_left  = res.step_left;
    assign o_dir_left   = res.dir_left;
    assign o_step_right = res.step_right;
    assign o_dir_right  = res.dir_right;
    assign o_pen_event  = res.pen_event;

endmodule
`default_nettype wire

FILE: tb/dual_quadrature_jog_stepper_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_quadrature_jog_stepper_top_test
// self-checking bench for the dual encoder jog stepper
// ----------------------------------------------------------------------------
// A queue of ticks feeds a bursty valid/ready driver; every accepted tick runs
// through an in-bench model of the sampler, the quadrature counters, the
// per-axis step bursts and the pen logic, and the predicted result is queued.
// A monitor with its own stall pattern (and one long hold-off that backs the
// block up) pops and compares each result field by field. The run walks
// through several register settings: a short directed pass over all phase
// transitions and button patterns, then random phases made mostly of clean
// encoder walks with button presses, mixed with raw noise.
// ----------------------------------------------------------------------------
module dual_quadrature_jog_stepper_top_test;

    import dqjs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 200;

    typedef struct packed {
        logic [1:0] lp;
        logic [1:0] rp;
        logic       lb;
        logic       rb;
    } t_tick;

    typedef struct packed {
        logic [1:0]             last;
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] snap;
        logic [STEP_WIDTH-1:0]  steps;
        t_dir                   dir;
    } t_axis;

    // every phase and button pattern from a zero start: walks both ways,
    // wrap below zero, illegal jumps, holds, presses and releases
    localparam t_tick DIRECTED_TICKS [24] = '{
        '{2'd1, 2'd2, 1'b0, 1'b0}, '{2'd3, 2'd3, 1'b1, 1'b0},
        '{2'd2, 2'd1, 1'b1, 1'b1}, '{2'd0, 2'd0, 1'b0, 1'b0},
        '{2'd2, 2'd1, 1'b0, 1'b1}, '{2'd3, 2'd3, 1'b0, 1'b0},
        '{2'd1, 2'd2, 1'b0, 1'b0}, '{2'd0, 2'd0, 1'b1, 1'b1},
        '{2'd3, 2'd3, 1'b0, 1'b0}, '{2'd0, 2'd0, 1'b0, 1'b0},
        '{2'd1, 2'd2, 1'b0, 1'b0}, '{2'd2, 2'd1, 1'b0, 1'b0},
        '{2'd1, 2'd2, 1'b1, 1'b0}, '{2'd1, 2'd2, 1'b0, 1'b0},
        '{2'd2, 2'd1, 1'b0, 1'b1}, '{2'd3, 2'd0, 1'b0, 1'b1},
        '{2'd0, 2'd3, 1'b0, 1'b0}, '{2'd0, 2'd3, 1'b1, 1'b1},
        '{2'd3, 2'd0, 1'b1, 1'b0}, '{2'd3, 2'd0, 1'b0, 1'b0},
        '{2'd2, 2'd1, 1'b0, 1'b0}, '{2'd2, 2'd1, 1'b0, 1'b0},
        '{2'd0, 2'd3, 1'b0, 1'b0}, '{2'd0, 2'd3, 1'b0, 1'b0}
    };

    // random phases: read interval, burst length, flips, tick count
    localparam int NUM_MODES = 9;
    localparam logic [15:0] MODE_INTERVAL [NUM_MODES] =
        '{16'd0, 16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd0, 16'd3, 16'd40, 16'd0};
    localparam logic [7:0] MODE_STEPS [NUM_MODES] =
        '{8'd3, 8'd1, 8'd255, 8'd0, 8'd5, 8'd2, 8'd7, 8'd16, 8'd1};
    localparam logic MODE_FLIP_L [NUM_MODES] =
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam logic MODE_FLIP_R [NUM_MODES] =
        '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int MODE_TICKS [NUM_MODES] = '{80, 70, 90, 50, 40, 80, 70, 60, 80};

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_left_phase   = 2'd0;
    logic [1:0]            i_right_phase  = 2'd0;
    logic                  i_left_button  = 1'b0;
    logic                  i_right_button = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic                  o_step_left;
    logic                  o_dir_left;
    logic                  o_step_right;
    logic                  o_dir_right;
    logic                  o_pen_event;

    dual_quadrature_jog_stepper_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_phase   (i_left_phase),
        .i_right_phase  (i_right_phase),
        .i_left_button  (i_left_button),
        .i_right_button (i_right_button),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_step_left    (o_step_left),
        .o_dir_left     (o_dir_left),
        .o_step_right   (o_step_right),
        .o_dir_right    (o_dir_right),
        .o_pen_event    (o_pen_event)
    );

    always #4 i_clk = ~i_clk;

    // ticks waiting to be offered, and step results predicted but not yet seen
    t_tick   tick_q[$];
    t_result step_results_q[$];

    int fail_count   = 0;
    int results_seen = 0;

    // bench copy of the registers and of the block state
    logic [TICK_WIDTH-1:0] cfg_interval;
    logic [STEP_WIDTH-1:0] cfg_steps;
    logic                  cfg_flip_l;
    logic                  cfg_flip_r;
    logic [TICK_WIDTH-1:0] elapsed;
    t_axis                 left_axis;
    t_axis                 right_axis;
    logic                  buttons_held;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // quadrature phase to position along the cycle 0,1,3,2 and back
    function automatic logic [1:0] phase_to_pos(input logic [1:0] ph);
        return {ph[1], ph[1] ^ ph[0]};
    endfunction

    function automatic logic [1:0] pos_to_phase(input logic [1:0] pos);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // one position forward counts up, one back counts down, a jump of two
    // or no change leaves the count alone
    function automatic void quad_sample(inout t_axis a, input logic [1:0] ph);
        logic [1:0] delta;
        delta = phase_to_pos(ph) - phase_to_pos(a.last);
        if (delta == 2'd1) begin
            a.count = a.count + 1'b1;
        end else if (delta == 2'd3) begin
            a.count = a.count - 1'b1;
        end
        a.last = ph;
    endfunction

    // idle axis latches the sign of its movement and loads a burst,
    // busy axis emits one step per tick
    function automatic void axis_advance(inout t_axis a, input logic flip,
                                         output logic stp, output logic dr);
        logic [COUNT_WIDTH-1:0] diff;
        stp = 1'b0;
        dr  = 1'b0;
        if (a.steps == '0) begin
            diff  = flip ? a.snap - a.count : a.count - a.snap;
            a.dir = (diff == '0) ? DIR_NONE : (diff[COUNT_WIDTH-1] ? DIR_NEG : DIR_POS);
            a.snap = a.count;
            if (a.dir != DIR_NONE) begin
                a.steps = cfg_steps;
            end
        end else begin
            stp     = (a.dir != DIR_NONE);
            dr      = (a.dir == DIR_POS);
            a.steps = a.steps - 1'b1;
        end
    endfunction

    function automatic t_result jog_tick(input t_tick t);
        t_result r;
        r = '0;
        // saturating tick counter, sample once the interval is exceeded
        if (elapsed != TICK_MAX) begin
            elapsed = elapsed + 1'b1;
        end
        if (elapsed > cfg_interval) begin
            elapsed = '0;
            quad_sample(left_axis, t.lp);
            quad_sample(right_axis, t.rp);
        end
        // pen pulse on release of both buttons after a press
        if (!buttons_held && (t.lb || t.rb)) begin
            buttons_held = 1'b1;
        end else if (buttons_held && !t.lb && !t.rb) begin
            buttons_held = 1'b0;
            r.pen_event  = 1'b1;
        end
        axis_advance(left_axis, cfg_flip_l, r.step_left, r.dir_left);
        axis_advance(right_axis, cfg_flip_r, r.step_right, r.dir_right);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of items with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_tick nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // item taken at this edge: predict from the payload still on the pins
            if (i_valid && o_ready) begin
                step_results_q.push_back(jog_tick({i_left_phase, i_right_phase,
                                                   i_left_button, i_right_button}));
            end
            // free to change what is offered only when nothing is pending
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    nxt = tick_q.pop_front();
                    i_valid        <= 1'b1;
                    i_left_phase   <= nxt.lp;
                    i_right_phase  <= nxt.rp;
                    i_left_button  <= nxt.lb;
                    i_right_button <= nxt.rb;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare results, stall on a rotating pattern
    // ------------------------------------------------------------------------
    logic [7:0] rx_cycle       = '0;
    int         hold_left      = 0;
    logic       long_hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        string   field_names [5];
        field_names = '{"step_left", "dir_left", "step_right", "dir_right", "pen_event"};
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_step_left, o_dir_left, o_step_right, o_dir_right, o_pen_event};
                if (step_results_q.size() == 0) begin
                    report($sformatf("result %0d with nothing expected", results_seen));
                end else begin
                    want = step_results_q.pop_front();
                    for (int b = 4; b >= 0; b--) begin
                        if (got[b] !== want[b]) begin
                            report($sformatf("result %0d %s got %b want %b", results_seen,
                                             field_names[4-b], got[b], want[b]));
                        end
                    end
                end
                results_seen++;
            end
            rx_cycle <= rx_cycle + 1'b1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AT_RESULT) begin
                // one long hold-off so the block backs up and stalls its input
                long_hold_done <= 1'b1;
                hold_left      <= HOLD_CYCLES;
                i_ready        <= 1'b0;
            end else begin
                case (rx_cycle[7:6])
                    2'd0:    i_ready <= 1'b1;
                    2'd1:    i_ready <= 1'($urandom_range(0, 1));
                    2'd2:    i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= (rx_cycle[1:0] == 2'd0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any item moving
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** dual_quadrature_jog_stepper_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // register write at the next edge, mirrored into the bench copy
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_READ_INTERVAL: cfg_interval = val[TICK_WIDTH-1:0];
            CFG_CLICK_STEPS:   cfg_steps    = val[STEP_WIDTH-1:0];
            CFG_FLIP_LEFT:     cfg_flip_l   = val[0];
            CFG_FLIP_RIGHT:    cfg_flip_r   = val[0];
            default: ;
        endcase
    endtask

    // all four registers, plus a write to an unused index that must be ignored
    task automatic set_mode(input logic [15:0] interval, input logic [7:0] steps,
                            input logic flip_l, input logic flip_r);
        cfg_write(CFG_READ_INTERVAL, interval);
        cfg_write(CFG_FLIP_RIGHT + 8'd1 + 8'($urandom_range(0, 251)), 16'($urandom));
        cfg_write(CFG_CLICK_STEPS, {8'd0, steps});
        cfg_write(CFG_FLIP_LEFT, {15'd0, flip_l});
        cfg_write(CFG_FLIP_RIGHT, {15'd0, flip_r});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // checked on the falling edge so every update of the rising edge is in
    task automatic wait_drained();
        @(negedge i_clk);
        while (tick_q.size() != 0 || i_valid || step_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // segments of clean encoder walks (each axis up, down or parked, buttons
    // toggling now and then) with some segments of raw noise
    logic [1:0] walk_pos_l = 2'd0;
    logic [1:0] walk_pos_r = 2'd0;
    logic       walk_btn_l = 1'b0;
    logic       walk_btn_r = 1'b0;

    task automatic queue_walk(input int n);
        int    seg;
        int    move_l;
        int    move_r;
        bit    noisy;
        t_tick t;
        while (n > 0) begin
            seg    = $urandom_range(4, 30);
            noisy  = ($urandom_range(0, 4) == 0);
            move_l = int'($urandom_range(0, 2)) - 1;
            move_r = int'($urandom_range(0, 2)) - 1;
            for (int k = 0; k < seg && n > 0; k++) begin
                if (noisy) begin
                    t = t_tick'(6'($urandom));
                    walk_pos_l = phase_to_pos(t.lp);
                    walk_pos_r = phase_to_pos(t.rp);
                    walk_btn_l = t.lb;
                    walk_btn_r = t.rb;
                end else begin
                    if ($urandom_range(0, 1)) walk_pos_l = walk_pos_l + 2'(move_l);
                    if ($urandom_range(0, 1)) walk_pos_r = walk_pos_r + 2'(move_r);
                    if ($urandom_range(0, 7) == 0) walk_btn_l = ~walk_btn_l;
                    if ($urandom_range(0, 7) == 0) walk_btn_r = ~walk_btn_r;
                    t = '{pos_to_phase(walk_pos_l), pos_to_phase(walk_pos_r),
                          walk_btn_l, walk_btn_r};
                end
                tick_q.push_back(t);
                n--;
            end
        end
    endtask

    initial begin
        cfg_interval = READ_INTERVAL_RST;
        cfg_steps    = CLICK_STEPS_RST;
        cfg_flip_l   = 1'b0;
        cfg_flip_r   = 1'b0;
        elapsed      = '0;
        left_axis    = '0;
        right_axis   = '0;
        buttons_held = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass: sample every tick, one step per click
        set_mode(16'd0, 8'd1, 1'b0, 1'b0);
        foreach (DIRECTED_TICKS[i]) tick_q.push_back(DIRECTED_TICKS[i]);
        wait_drained();

        // random phases over the register settings, extremes included
        for (int m = 0; m < NUM_MODES; m++) begin
            set_mode(MODE_INTERVAL[m], MODE_STEPS[m], MODE_FLIP_L[m], MODE_FLIP_R[m]);
            queue_walk(MODE_TICKS[m]);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("** dual_quadrature_jog_stepper_top: PASSED **");
        end else begin
            $display("** dual_quadrature_jog_stepper_top: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
